>>> rtl/core/qph_pkg.sv
package qph_pkg;

    // Width of the externally computed key hash.
    localparam int HASH_BITS  = 32;
    // Counter wide enough to walk every hash bit in the serial reducer.
    localparam int HASH_CNT_W = $clog2(HASH_BITS + 1);

    // Operation carried in tuser on the input side.
    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_PUT    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    // Per-slot occupancy kept in the table memory.
    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_LIVE  = 2'd1,
        SLOT_TOMB  = 2'd2
    } slot_state_t;

    // Controller states.
    typedef enum logic [2:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_HASH,
        FSM_READ,
        FSM_EVAL,
        FSM_CLEAR,
        FSM_RESP
    } fsm_state_t;

    // Outcome of examining one probed slot.
    typedef enum logic [2:0] {
        EV_NEXT,
        EV_INSERT,
        EV_REPLACE,
        EV_FOUND,
        EV_REMOVE,
        EV_MISS
    } eval_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    hash_step;
        logic    cnt_clear;
        logic    sweep;
        logic    rd;
        logic    advance;
        logic    commit;
        logic    res_set;
        status_t res_status;
        logic    res_hit;
        logic    res_take_old;
        logic    emit;
    } qph_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic  hash_done;
        logic  is_clear;
        logic  early_miss;
        logic  early_full;
        eval_t eval;
        logic  last_probe;
        logic  sweep_last;
        logic  out_free;
    } qph_stat_t;

endpackage

>>> rtl/core/qph_datapath.sv
module qph_datapath #(
    parameter int TABLE_SIZE = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  qph_pkg::qph_cmd_t                   cmd,
    output qph_pkg::qph_stat_t                  stat,
    input  qph_pkg::op_t                        in_op,
    input  logic [KEY_BITS-1:0]                 in_key,
    input  logic [qph_pkg::HASH_BITS-1:0]       in_hash,
    input  logic [VALUE_BITS-1:0]               in_value,
    input  logic                                cfg_wr_en,
    input  logic [$clog2(TABLE_SIZE+1)-1:0]     cfg_wr_data,
    input  logic                                m_ready,
    output logic                                m_valid,
    output qph_pkg::status_t                    m_status,
    output logic                                m_hit,
    output logic [VALUE_BITS-1:0]               m_old,
    output logic [$clog2(TABLE_SIZE+1)-1:0]     m_live
);
    import qph_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
    localparam int MEM_W  = 2 + KEY_BITS + VALUE_BITS;
    localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
    localparam logic [ADDR_W:0]   SIZE_W     = (ADDR_W + 1)'(TABLE_SIZE);
    localparam logic [ADDR_W-1:0] LAST_SLOT  = ADDR_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0]  FILL_RESET = CNT_W'(TABLE_SIZE / 2);

    // Captured operation.
    op_t                    op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [HASH_BITS-1:0]   hash_reg;
    logic [VALUE_BITS-1:0]  val_reg;

    // Probe walk.
    logic [ADDR_W-1:0]      slot_reg;
    logic [ADDR_W-1:0]      probe_reg;
    logic [HASH_CNT_W-1:0]  hcnt_reg;

    // Occupancy and configuration.
    logic [CNT_W-1:0]       entry_reg;
    logic [CNT_W-1:0]       used_reg;
    logic [CNT_W-1:0]       fill_limit_reg;
    logic [ADDR_W-1:0]      clr_idx_reg;

    // Table memory and its registered read port.
    logic [MEM_W-1:0]       mem [TABLE_SIZE];
    logic [MEM_W-1:0]       rd_reg;

    // Pending result and output beat.
    status_t                res_status_reg;
    logic                   res_hit_reg;
    logic [VALUE_BITS-1:0]  res_old_reg;
    logic                   m_valid_reg;
    status_t                m_status_reg;
    logic                   m_hit_reg;
    logic [VALUE_BITS-1:0]  m_old_reg;
    logic [CNT_W-1:0]       m_live_reg;

    slot_state_t            rd_state;
    logic [KEY_BITS-1:0]    rd_key;
    logic [VALUE_BITS-1:0]  rd_val;
    logic                   key_eq;
    eval_t                  eval;
    logic [ADDR_W:0]        step;
    logic [ADDR_W:0]        step_mod;
    logic [ADDR_W:0]        slot_sum;
    logic [ADDR_W-1:0]      slot_adv;
    logic [ADDR_W:0]        red_t;
    logic [ADDR_W-1:0]      red_next;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_wa;
    logic [MEM_W-1:0]       mem_wd;

    assign rd_state = slot_state_t'(rd_reg[MEM_W-1 -: 2]);
    assign rd_key   = rd_reg[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
    assign rd_val   = rd_reg[VALUE_BITS-1:0];
    assign key_eq   = (rd_key == key_reg);

    // Classify the slot that was just read.
    always_comb begin
        eval = EV_NEXT;
        if (op_reg == OP_PUT) begin
            if (rd_state == SLOT_EMPTY || rd_state == SLOT_TOMB) begin
                eval = EV_INSERT;
            end else if (key_eq) begin
                eval = EV_REPLACE;
            end
        end else begin
            if (rd_state == SLOT_EMPTY) begin
                eval = EV_MISS;
            end else if (rd_state == SLOT_TOMB) begin
                eval = EV_NEXT;
            end else if (key_eq) begin
                eval = (op_reg == OP_REMOVE) ? EV_REMOVE : EV_FOUND;
            end
        end
    end

    // Next probe slot: the offset grows by i for even i and by i+2 for odd i.
    always_comb begin
        step     = probe_reg[0] ? ({1'b0, probe_reg} + (ADDR_W + 1)'(2))
                                : {1'b0, probe_reg};
        step_mod = (step >= SIZE_W) ? step - SIZE_W : step;
        slot_sum = {1'b0, slot_reg} + step_mod;
        slot_adv = (slot_sum >= SIZE_W) ? ADDR_W'(slot_sum - SIZE_W)
                                        : slot_sum[ADDR_W-1:0];
    end

    // One bit of the serial hash reduction for tables that are not a power of two.
    always_comb begin
        red_t    = {slot_reg, hash_reg[HASH_BITS-1]};
        red_next = (red_t >= SIZE_W) ? ADDR_W'(red_t - SIZE_W) : red_t[ADDR_W-1:0];
    end

    // Status toward the controller.
    always_comb begin
        stat.hash_done  = (hcnt_reg == '0);
        stat.is_clear   = (op_reg == OP_CLEAR);
        stat.early_miss = (op_reg == OP_GET) && (entry_reg == '0);
        stat.early_full = (op_reg == OP_PUT) && (used_reg >= fill_limit_reg);
        stat.eval       = eval;
        stat.last_probe = (probe_reg == LAST_SLOT);
        stat.sweep_last = (clr_idx_reg == LAST_SLOT);
        stat.out_free   = !m_valid_reg || m_ready;
    end

    // Memory write port: clearing sweep or an update of the probed slot.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = slot_reg;
        mem_wd = {SLOT_EMPTY, key_reg, val_reg};
        if (cmd.sweep) begin
            mem_we = 1'b1;
            mem_wa = clr_idx_reg;
        end else if (cmd.commit) begin
            case (eval)
                EV_INSERT: begin
                    mem_we = 1'b1;
                    mem_wd = {SLOT_LIVE, key_reg, val_reg};
                end
                EV_REPLACE: begin
                    mem_we = 1'b1;
                    mem_wd = {SLOT_LIVE, rd_key, val_reg};
                end
                EV_REMOVE: begin
                    mem_we = 1'b1;
                    mem_wd = {SLOT_TOMB, rd_key, rd_val};
                end
                default: begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    // Table memory.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd) begin
            rd_reg <= mem[slot_reg];
        end
    end

    // Operation capture, hash reduction and probe walk.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_op;
            key_reg   <= in_key;
            hash_reg  <= in_hash;
            val_reg   <= in_value;
            probe_reg <= '0;
            if (IS_POW2) begin
                slot_reg <= in_hash[ADDR_W-1:0];
                hcnt_reg <= '0;
            end else begin
                slot_reg <= '0;
                hcnt_reg <= HASH_CNT_W'(HASH_BITS);
            end
        end else if (cmd.hash_step && hcnt_reg != '0) begin
            slot_reg <= red_next;
            hash_reg <= {hash_reg[HASH_BITS-2:0], 1'b0};
            hcnt_reg <= hcnt_reg - HASH_CNT_W'(1);
        end else if (cmd.advance) begin
            slot_reg  <= slot_adv;
            probe_reg <= probe_reg + ADDR_W'(1);
        end
    end

    // Counters, sweep index and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg      <= '0;
            used_reg       <= '0;
            clr_idx_reg    <= '0;
            fill_limit_reg <= FILL_RESET;
        end else begin
            if (cfg_wr_en) begin
                fill_limit_reg <= cfg_wr_data;
            end
            if (cmd.cnt_clear) begin
                entry_reg   <= '0;
                used_reg    <= '0;
                clr_idx_reg <= '0;
            end else if (cmd.sweep) begin
                clr_idx_reg <= (clr_idx_reg == LAST_SLOT) ? '0
                                                          : clr_idx_reg + ADDR_W'(1);
            end else if (cmd.commit) begin
                case (eval)
                    EV_INSERT: begin
                        entry_reg <= entry_reg + CNT_W'(1);
                        if (rd_state == SLOT_EMPTY) begin
                            used_reg <= used_reg + CNT_W'(1);
                        end
                    end
                    EV_REMOVE: begin
                        if (entry_reg != '0) begin
                            entry_reg <= entry_reg - CNT_W'(1);
                        end
                    end
                    default: begin
                        entry_reg <= entry_reg;
                    end
                endcase
            end
        end
    end

    // Pending result.
    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            res_status_reg <= cmd.res_status;
            res_hit_reg    <= cmd.res_hit;
            res_old_reg    <= cmd.res_take_old ? rd_val : '0;
        end
    end

    // Output register: holds a finished beat until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status_reg <= res_status_reg;
            m_hit_reg    <= res_hit_reg;
            m_old_reg    <= res_old_reg;
            m_live_reg   <= entry_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_hit    = m_hit_reg;
    assign m_old    = m_old_reg;
    assign m_live   = m_live_reg;

endmodule

>>> rtl/core/qph_ctrl.sv
module qph_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  qph_pkg::qph_stat_t stat,
    output qph_pkg::qph_cmd_t  cmd
);
    import qph_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_INIT: begin
                if (stat.sweep_last) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                if (s_tvalid) begin
                    state_next = FSM_HASH;
                end
            end
            FSM_HASH: begin
                if (stat.is_clear) begin
                    state_next = FSM_CLEAR;
                end else if (stat.early_miss || stat.early_full) begin
                    state_next = FSM_RESP;
                end else if (stat.hash_done) begin
                    state_next = FSM_READ;
                end
            end
            FSM_READ: begin
                state_next = FSM_EVAL;
            end
            FSM_EVAL: begin
                if (stat.eval == EV_NEXT && !stat.last_probe) begin
                    state_next = FSM_READ;
                end else begin
                    state_next = FSM_RESP;
                end
            end
            FSM_CLEAR: begin
                if (stat.sweep_last) begin
                    state_next = FSM_RESP;
                end
            end
            FSM_RESP: begin
                if (stat.out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_INIT;
            end
        endcase
    end

    // Commands.
    always_comb begin
        s_tready         = 1'b0;
        cmd              = '0;
        cmd.res_status   = STAT_DONE;
        case (state_reg)
            FSM_INIT: begin
                cmd.sweep = 1'b1;
            end
            FSM_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            FSM_HASH: begin
                cmd.hash_step = 1'b1;
                if (stat.is_clear) begin
                    cmd.cnt_clear = 1'b1;
                end else if (stat.early_miss) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_NOT_FOUND;
                end else if (stat.early_full) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_FULL;
                end
            end
            FSM_READ: begin
                cmd.rd = 1'b1;
            end
            FSM_EVAL: begin
                case (stat.eval)
                    EV_NEXT: begin
                        if (stat.last_probe) begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = STAT_FULL;
                        end else begin
                            cmd.advance = 1'b1;
                        end
                    end
                    EV_INSERT: begin
                        cmd.commit  = 1'b1;
                        cmd.res_set = 1'b1;
                    end
                    EV_REPLACE, EV_REMOVE: begin
                        cmd.commit       = 1'b1;
                        cmd.res_set      = 1'b1;
                        cmd.res_hit      = 1'b1;
                        cmd.res_take_old = 1'b1;
                    end
                    EV_FOUND: begin
                        cmd.res_set      = 1'b1;
                        cmd.res_hit      = 1'b1;
                        cmd.res_take_old = 1'b1;
                    end
                    EV_MISS: begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = STAT_NOT_FOUND;
                    end
                    default: begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = STAT_FULL;
                    end
                endcase
            end
            FSM_CLEAR: begin
                cmd.sweep   = 1'b1;
                cmd.res_set = stat.sweep_last;
            end
            FSM_RESP: begin
                cmd.emit = stat.out_free;
            end
            default: begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/quadratic_probe_hash_table_core.sv
// Open-addressing key/value table with quadratic probing. Each input beat carries an
// operation in s_tuser (get, put, remove, clear) and key, hash and value in s_tdata; each
// produces exactly one result beat. Slot i of the probe path is
// (hash + floor(i/2) + floor(i*i/2)) mod TABLE_SIZE, walked incrementally. The table lives
// in one single-port memory with a registered read, so every probe takes a read state, then
// a compare state. For a get, put or remove the block goes from the accepting state through
// the hash state, the read and compare states of each slot probed (none for an early
// refusal) and the result state, where the result beat is registered, and s_tready returns
// in the idle state after it; a probing operation first runs a serial, bit-by-bit hash
// reduction when TABLE_SIZE is not a power of two. A clear walks the whole memory before it
// registers its result. After reset the block runs the same clearing pass, with
// s_tready low, before it takes the first beat. The result sits in an output register, so
// the next beat is accepted while the previous result waits; a finished result that cannot
// enter the output register holds the block, and s_tready stays low, until the sink takes
// the waiting beat.
module quadratic_probe_hash_table_core #(
    parameter int TABLE_SIZE = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    // Input channel.
    input  logic                                              s_tvalid,
    output logic                                              s_tready,
    // s_tdata from bit 0 up: key, key_hash, value, zero padding.
    input  logic [((KEY_BITS+qph_pkg::HASH_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser from bit 0 up: op.
    input  logic [1:0]                                        s_tuser,
    // Result channel.
    output logic                                              m_tvalid,
    input  logic                                              m_tready,
    // m_tdata from bit 0 up: old_value, live_count, zero padding.
    output logic [((VALUE_BITS+$clog2(TABLE_SIZE+1)+7)/8)*8-1:0] m_tdata,
    // m_tuser from bit 0 up: status, hit.
    output logic [2:0]                                        m_tuser,
    // Fill limit register.
    input  logic                                              cfg_wr_en,
    input  logic [$clog2(TABLE_SIZE+1)-1:0]                   cfg_wr_data
);
    import qph_pkg::*;

    localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
    localparam int MDATA_W = ((VALUE_BITS + CNT_W + 7) / 8) * 8;

    qph_cmd_t               cmd;
    qph_stat_t              stat;
    status_t                m_status;
    logic                   m_hit;
    logic [VALUE_BITS-1:0]  m_old;
    logic [CNT_W-1:0]       m_live;

    // Sequencing of probes, sweeps and result hand-off.
    qph_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Table memory, counters and result registers.
    qph_datapath #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_op       (op_t'(s_tuser)),
        .in_key      (s_tdata[KEY_BITS-1:0]),
        .in_hash     (s_tdata[KEY_BITS+HASH_BITS-1:KEY_BITS]),
        .in_value    (s_tdata[KEY_BITS+HASH_BITS+VALUE_BITS-1:KEY_BITS+HASH_BITS]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_ready     (m_tready),
        .m_valid     (m_tvalid),
        .m_status    (m_status),
        .m_hit       (m_hit),
        .m_old       (m_old),
        .m_live      (m_live)
    );

    // Pack the result beat.
    assign m_tdata = MDATA_W'({m_live, m_old});
    assign m_tuser = {m_hit, m_status};

endmodule

>>> test/quadratic_probe_hash_table_core_test.sv
`timescale 1ns / 1ps

module quadratic_probe_hash_table_core_test;
    import qph_pkg::*;

    localparam int TABLE_SLOTS = 256;
    localparam int IN_DATA_W   = ((32 + HASH_BITS + 32 + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((32 + 9 + 7) / 8) * 8;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 600;
    localparam int POOL_MAX    = 32;

    // One operation as it goes into the table.
    typedef struct packed {
        op_t         op;
        logic [31:0] key;
        logic [31:0] key_hash;
        logic [31:0] value;
    } table_req_t;

    // One response as the table reports it.
    typedef struct packed {
        status_t     status;
        logic        hit;
        logic [31:0] old_value;
        logic [8:0]  live_count;
    } table_resp_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [8:0]            cfg_wr_data = '0;

    // Shadow copy of the table used to work out each response.
    logic [31:0]  shadow_key [TABLE_SLOTS];
    logic [31:0]  shadow_val [TABLE_SLOTS];
    slot_state_t  shadow_st [TABLE_SLOTS];
    int unsigned  shadow_live;
    int unsigned  shadow_used;
    int unsigned  shadow_fill_limit;

    table_req_t  pending_ops [$];
    table_resp_t expected_resps [$];
    table_req_t  driven_op;
    int          beats_in = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          errors = 0;
    int          stall_cycles = 0;
    int          hold_left = 0;
    logic        held_off = 1'b0;

    logic [31:0] pool_key [POOL_MAX];
    logic [31:0] pool_hash [POOL_MAX];
    logic [31:0] filled_key [$];
    logic [31:0] filled_hash [$];

    quadratic_probe_hash_table_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Slot visited on probe number i of a walk that starts from the given hash.
    function automatic int unsigned probe_slot(logic [31:0] key_hash, int unsigned i);
        longint unsigned sum;
        sum = longint'(key_hash) + (i >> 1) + ((i * i) >> 1);
        return 32'(sum % TABLE_SLOTS);
    endfunction

    // Apply one operation to the shadow table and return the response it must give.
    function automatic table_resp_t apply_table_op(table_req_t req);
        table_resp_t resp;
        int unsigned s;
        logic        decided;
        resp = '{status: STAT_DONE, hit: 1'b0, old_value: '0, live_count: '0};
        decided = 1'b0;
        if (req.op == OP_CLEAR) begin
            for (int k = 0; k < TABLE_SLOTS; k++) shadow_st[k] = SLOT_EMPTY;
            shadow_live = 0;
            shadow_used = 0;
        end else if (req.op == OP_GET && shadow_live == 0) begin
            resp.status = STAT_NOT_FOUND;
        end else if (req.op == OP_PUT && shadow_used >= shadow_fill_limit) begin
            resp.status = STAT_FULL;
        end else begin
            // Walk the probe path; running out of probes reports full.
            resp.status = STAT_FULL;
            for (int i = 0; i < TABLE_SLOTS && !decided; i++) begin
                s = probe_slot(req.key_hash, i);
                if (req.op == OP_PUT) begin
                    if (shadow_st[s] != SLOT_LIVE) begin
                        if (shadow_st[s] == SLOT_EMPTY) shadow_used++;
                        shadow_live++;
                        shadow_st[s] = SLOT_LIVE;
                        shadow_key[s] = req.key;
                        shadow_val[s] = req.value;
                        resp.status = STAT_DONE;
                        decided = 1'b1;
                    end else if (shadow_key[s] == req.key) begin
                        resp.old_value = shadow_val[s];
                        resp.hit = 1'b1;
                        shadow_val[s] = req.value;
                        resp.status = STAT_DONE;
                        decided = 1'b1;
                    end
                end else if (shadow_st[s] == SLOT_EMPTY) begin
                    resp.status = STAT_NOT_FOUND;
                    decided = 1'b1;
                end else if (shadow_st[s] == SLOT_LIVE && shadow_key[s] == req.key) begin
                    resp.old_value = shadow_val[s];
                    resp.hit = 1'b1;
                    resp.status = STAT_DONE;
                    if (req.op == OP_REMOVE) begin
                        shadow_st[s] = SLOT_TOMB;
                        if (shadow_live > 0) shadow_live--;
                    end
                    decided = 1'b1;
                end
            end
        end
        resp.live_count = shadow_live[8:0];
        return resp;
    endfunction

    // Sender: offer queued operations, hold each beat until it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_resps.push_back(apply_table_op(driven_op));
                beats_in <= beats_in + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    driven_op = pending_ops.pop_front();
                    s_tdata <= {driven_op.value, driven_op.key_hash, driven_op.key};
                    s_tuser <= driven_op.op;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness, with one long hold-off early on to back the block up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!held_off && beats_in >= HOLD_AT) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            held_off <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each result beat against the oldest outstanding response.
    always @(posedge aclk) begin : result_check
        table_resp_t got;
        table_resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tuser[1:0]);
            got.hit = m_tuser[2];
            got.old_value = m_tdata[31:0];
            got.live_count = m_tdata[40:32];
            if (expected_resps.size() == 0) begin
                $error("result beat with no response outstanding");
                errors++;
            end else begin
                want = expected_resps.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    errors++;
                end
                if (got.old_value !== want.old_value) begin
                    $error("old_value: expected %h, got %h", want.old_value, got.old_value);
                    errors++;
                end
                if (got.live_count !== want.live_count) begin
                    $error("live_count: expected %0d, got %0d", want.live_count,
                           got.live_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_op(op_t op, logic [31:0] key, logic [31:0] key_hash,
                            logic [31:0] value);
        table_req_t req;
        req = '{op: op, key: key, key_hash: key_hash, value: value};
        pending_ops.push_back(req);
    endtask

    // Let every queued beat go out and every response come back.
    task automatic wait_for_drain();
        while (pending_ops.size() != 0 || expected_resps.size() != 0 || s_tvalid)
            @(posedge aclk);
    endtask

    // Start a phase once the block is idle: new idle rates and a new fill limit.
    task automatic begin_phase(int fill_limit, int send_pct, int recv_pct);
        wait_for_drain();
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
        cfg_wr_data <= fill_limit[8:0];
        cfg_wr_en <= 1'b1;
        shadow_fill_limit = fill_limit;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Draw a set of keys whose hashes crowd into a few home slots.
    task automatic draw_key_pool(int pool_n, int home_spread);
        for (int k = 0; k < pool_n; k++) begin
            pool_key[k] = $urandom();
            pool_hash[k] = ($urandom() & 32'hFFFF_FF00) | $urandom_range(0, home_spread - 1);
        end
    endtask

    // Mixed traffic over the key pool, with some foreign keys as noise.
    task automatic queue_random_ops(int count, int pool_n, int clear_pct);
        op_t         op;
        int          pick;
        int          r;
        logic [31:0] key;
        logic [31:0] key_hash;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < clear_pct) begin
                op = OP_CLEAR;
            end else begin
                r = $urandom_range(0, 9);
                op = (r < 4) ? OP_PUT : (r < 7) ? OP_GET : OP_REMOVE;
            end
            if ($urandom_range(0, 9) == 0) begin
                key = $urandom();
                key_hash = $urandom();
            end else begin
                pick = $urandom_range(0, pool_n - 1);
                key = pool_key[pick];
                key_hash = pool_hash[pick];
            end
            queue_op(op, key, key_hash, $urandom());
        end
    endtask

    initial begin
        for (int k = 0; k < TABLE_SLOTS; k++) begin
            shadow_key[k] = '0;
            shadow_val[k] = '0;
            shadow_st[k] = SLOT_EMPTY;
        end
        shadow_live = 0;
        shadow_used = 0;
        shadow_fill_limit = 128;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // The block sweeps its memory after reset before it takes a beat.
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);

        // Directed: empty table, replace, collisions, tombstones, fill limit, clear.
        begin_phase(3, 10, 69);
        queue_op(OP_GET, 32'h0, 32'h0, 32'h0);
        queue_op(OP_REMOVE, 32'h0, 32'h0, 32'hFFFF_FFFF);
        queue_op(OP_PUT, 32'h0, 32'h0, 32'h0);
        queue_op(OP_PUT, 32'h0, 32'h0, 32'hFFFF_FFFF);
        queue_op(OP_GET, 32'h0, 32'h0, 32'h0);
        queue_op(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'h5A5A_5A5A);
        queue_op(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'h0);
        queue_op(OP_REMOVE, 32'h0, 32'h0, 32'h0);
        queue_op(OP_GET, 32'h0, 32'h0, 32'h0);
        queue_op(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'h0);
        queue_op(OP_PUT, 32'h1, 32'h0000_0100, 32'hA5A5_A5A5);
        queue_op(OP_PUT, 32'h2, 32'h0000_0007, 32'h1234_5678);
        queue_op(OP_PUT, 32'h3, 32'h0000_0008, 32'h8765_4321);
        queue_op(OP_PUT, 32'h2, 32'h0000_0007, 32'h0000_0001);
        queue_op(OP_REMOVE, 32'h3, 32'h0000_0008, 32'h0);
        queue_op(OP_GET, 32'h2, 32'h0000_0007, 32'h0);
        queue_op(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(OP_GET, 32'h2, 32'h0000_0007, 32'h0);
        queue_op(OP_PUT, 32'h3, 32'h0000_0008, 32'hFFFF_FFFF);
        queue_op(OP_CLEAR, 32'h0, 32'h0, 32'h0);

        // Default load with crowded home slots; the long receiver hold-off lands here.
        begin_phase(128, 10, 69);
        draw_key_pool(24, 8);
        queue_random_ops(350, 24, 2);

        // Smallest fill limit: a single used slot refuses further puts until a clear.
        begin_phase(1, 10, 69);
        draw_key_pool(8, 4);
        queue_random_ops(200, 8, 6);

        // Largest fill limit: fill the table, miss on a full table, then tombstones.
        begin_phase(256, 69, 10);
        queue_op(OP_CLEAR, 32'h0, 32'h0, 32'h0);
        filled_key.delete();
        filled_hash.delete();
        for (int n = 0; n < 260; n++) begin
            filled_key.push_back($urandom());
            filled_hash.push_back($urandom());
            queue_op(OP_PUT, filled_key[n], filled_hash[n], $urandom());
        end
        for (int n = 0; n < 30; n++) queue_op(OP_GET, $urandom(), $urandom(), $urandom());
        for (int n = 0; n < 150; n++)
            queue_op(OP_REMOVE, filled_key[n], filled_hash[n], $urandom());
        for (int n = 0; n < 30; n++) queue_op(OP_GET, $urandom(), $urandom(), $urandom());

        // Random fill limit on top of the tombstones left behind.
        begin_phase($urandom_range(2, 255), 69, 10);
        draw_key_pool(32, 16);
        queue_random_ops(350, 32, 2);

        // No idling on either side, tight key set.
        begin_phase(256, 0, 0);
        draw_key_pool(8, 2);
        queue_random_ops(400, 8, 3);

        wait_for_drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0 && expected_resps.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
